// ===== rtl/pbv_pkg.sv =====
// Shared types, constants and the note table for the pitch bend / vibrato core.
package pbv_pkg;

  localparam int QUEUE_DEPTH = 2;

  // Reciprocals for the constant divisors, each with its shift.
  localparam logic [13:0] RECIP_5   = 14'd13108;    // >> 16
  localparam logic [11:0] RECIP_20  = 12'd3277;     // >> 16
  localparam logic [21:0] RECIP_25  = 22'd2684355;  // >> 26
  localparam logic [11:0] RECIP_50  = 12'd2622;     // >> 17
  localparam logic [19:0] RECIP_100 = 20'd671089;   // >> 26

  localparam logic [7:0]  WRAP_2P16_MOD_200 = 8'd136;
  localparam logic [6:0]  PCT_FULL   = 7'd100;
  localparam logic signed [9:0] CLAMP_CENTS = 10'sd250;
  localparam logic signed [15:0] LIN_COEF = 16'sd38;
  localparam logic [19:0] SQ_COEF = 20'd11;
  localparam logic signed [18:0] Q16_ONE = 19'sd65536;
  localparam logic [30:0] Q16_HALF = 31'd32768;

  typedef struct packed {
    logic [2:0]        note;
    logic              modulate;
    logic signed [8:0] bend;
    logic [5:0]        depth;
    logic [23:0]       folded_ms;  // congruent to elapsed ms modulo 200
    logic [18:0]       vol_prod;   // min(pct,100) * 4095
  } front_item_t;

  function automatic logic [12:0] base_hz(input logic [2:0] note);
    logic [12:0] f;
    unique case (note)
      3'd0: f = 13'd2093;
      3'd1: f = 13'd2349;
      3'd2: f = 13'd2637;
      3'd3: f = 13'd2794;
      3'd4: f = 13'd3136;
      3'd5: f = 13'd3520;
      3'd6: f = 13'd3951;
      3'd7: f = 13'd4186;
      default: f = 13'd2093;
    endcase
    return f;
  endfunction

endpackage

// ===== rtl/pbv_front.sv =====
// Front end: takes a command and reduces it to bend, depth, folded time and volume product.
module pbv_front import pbv_pkg::*; (
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         note_sel,
  input  logic [6:0]         volume_pct,
  input  logic               modulate,
  input  logic signed [10:0] stick_x,
  input  logic signed [10:0] stick_y,
  input  logic [31:0]        lfo_elapsed_ms,
  output logic               push,
  output front_item_t        item
);

  logic [10:0] x_mag;
  logic [24:0] x_prod;
  logic [8:0]  bend_mag;
  logic [21:0] y_prod;
  logic [6:0]  vol_sat;
  logic [23:0] hi_part;

  always_comb begin
    x_mag    = stick_x[10] ? (~stick_x + 11'd1) : stick_x;
    x_prod   = 25'(x_mag) * 25'(RECIP_5);
    bend_mag = x_prod[24:16];
    y_prod   = 22'(stick_y[9:0]) * 22'(RECIP_20);
    vol_sat  = (volume_pct > PCT_FULL) ? PCT_FULL : volume_pct;
    hi_part  = 24'(lfo_elapsed_ms[31:16]) * 24'(WRAP_2P16_MOD_200);

    item.note      = note_sel;
    item.modulate  = modulate;
    item.bend      = stick_x[10] ? -$signed(bend_mag) : $signed(bend_mag);
    item.depth     = (!stick_y[10] && stick_y != '0) ? y_prod[21:16] : 6'd0;
    item.folded_ms = hi_part + 24'(lfo_elapsed_ms[15:0]);
    item.vol_prod  = {vol_sat, 12'd0} - 19'(vol_sat);
  end

  assign push = start && !busy;

endmodule

// ===== rtl/pbv_queue.sv =====
// Two-entry queue between front and back.
module pbv_queue import pbv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  front_item_t push_item,
  input  logic        pop,
  output front_item_t head,
  output logic        head_valid,
  output logic        full
);

  front_item_t slots [QUEUE_DEPTH];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_pop;

  assign do_pop     = pop && (count != 2'd0);
  assign head       = slots[rd_ptr];
  assign head_valid = (count != 2'd0);
  assign full       = (count == 2'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(do_pop);
    end
  end

endmodule

// ===== rtl/pbv_back.sv =====
// Back end: six-stage pipeline from classified item to frequency, volume and cents.
module pbv_back import pbv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  front_item_t        in_item,
  output logic               done,
  output logic [12:0]        tone_freq_hz,
  output logic [11:0]        drive_volume,
  output logic signed [8:0]  applied_cents
);

  logic [5:0] vld;

  // stage 1
  logic [20:0] s1_y;
  logic [2:0]  s1_low;
  logic [16:0] s1_q;
  logic [11:0] s1_drive;
  logic [2:0]  s1_note;
  logic        s1_mod;
  logic signed [8:0] s1_bend;
  logic [5:0]  s1_depth;
  logic [42:0] q_prod;
  logic [38:0] v_prod;

  // stage 2
  logic [11:0] s2_m;
  logic        s2_neg;
  logic [11:0] s2_drive;
  logic [2:0]  s2_note;
  logic        s2_mod;
  logic signed [8:0] s2_bend;
  logic [20:0] rem_full;
  logic [7:0]  phase;
  logic [5:0]  tri_mag;
  logic        tri_neg;

  // stage 3
  logic signed [8:0] s3_total;
  logic [11:0] s3_drive;
  logic [2:0]  s3_note;
  logic [23:0] l_prod;
  logic [6:0]  lfo_mag;
  logic signed [9:0] lfo;
  logic signed [9:0] sum;
  logic signed [8:0] total_next;

  // stage 4
  logic [15:0] s4_tsq;
  logic signed [8:0] s4_total;
  logic [11:0] s4_drive;
  logic [2:0]  s4_note;
  logic signed [8:0] neg_total;
  logic [7:0]  t_abs;

  // stage 5
  logic [16:0] s5_scale;
  logic signed [8:0] s5_total;
  logic [11:0] s5_drive;
  logic [2:0]  s5_note;
  logic signed [15:0] lin;
  logic [19:0] sq_prod;
  logic signed [18:0] scale_s;

  // stage 6
  logic [30:0] f_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], in_valid};
    end
  end

  assign done = vld[5];

  // stage 1: divide the folded time's upper bits (time / 8) by 25 and the volume product by 100
  always_comb begin
    q_prod = 43'(in_item.folded_ms[23:3]) * 43'(RECIP_25);
    v_prod = 39'(in_item.vol_prod) * 39'(RECIP_100);
  end

  always_ff @(posedge clk) begin
    s1_y     <= in_item.folded_ms[23:3];
    s1_low   <= in_item.folded_ms[2:0];
    s1_q     <= q_prod[42:26];
    s1_drive <= v_prod[37:26];
    s1_note  <= in_item.note;
    s1_mod   <= in_item.modulate;
    s1_bend  <= in_item.bend;
    s1_depth <= in_item.depth;
  end

  // stage 2: triangle phase and magnitude times depth
  always_comb begin
    rem_full = s1_y - 21'(s1_q) * 21'd25;
    phase    = {rem_full[4:0], s1_low};
    priority if (phase < 8'd50) begin
      tri_mag = 6'(phase);
      tri_neg = 1'b0;
    end else if (phase < 8'd100) begin
      tri_mag = 6'(8'd100 - phase);
      tri_neg = 1'b0;
    end else if (phase < 8'd150) begin
      tri_mag = 6'(phase - 8'd100);
      tri_neg = 1'b1;
    end else begin
      tri_mag = 6'(8'd200 - phase);
      tri_neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    s2_m     <= 12'(tri_mag) * 12'(s1_depth);
    s2_neg   <= tri_neg;
    s2_drive <= s1_drive;
    s2_note  <= s1_note;
    s2_mod   <= s1_mod;
    s2_bend  <= s1_bend;
  end

  // stage 3: vibrato offset, sum and clamp
  always_comb begin
    l_prod  = 24'(s2_m) * 24'(RECIP_50);
    lfo_mag = l_prod[23:17];
    lfo     = s2_neg ? -$signed({3'b000, lfo_mag}) : $signed({3'b000, lfo_mag});
    sum     = {s2_bend[8], s2_bend} + lfo;
    priority if (!s2_mod) begin
      total_next = 9'sd0;
    end else if (sum > CLAMP_CENTS) begin
      total_next = 9'(CLAMP_CENTS);
    end else if (sum < -CLAMP_CENTS) begin
      total_next = 9'(-CLAMP_CENTS);
    end else begin
      total_next = sum[8:0];
    end
  end

  always_ff @(posedge clk) begin
    s3_total <= total_next;
    s3_drive <= s2_drive;
    s3_note  <= s2_note;
  end

  // stage 4: square of the offset
  always_comb begin
    neg_total = -s3_total;
    t_abs     = s3_total[8] ? neg_total[7:0] : s3_total[7:0];
  end

  always_ff @(posedge clk) begin
    s4_tsq   <= 16'(t_abs) * 16'(t_abs);
    s4_total <= s3_total;
    s4_drive <= s3_drive;
    s4_note  <= s3_note;
  end

  // stage 5: Q16 scale
  always_comb begin
    lin     = $signed({{7{s4_total[8]}}, s4_total}) * LIN_COEF;
    sq_prod = 20'(s4_tsq) * SQ_COEF;
    scale_s = Q16_ONE + {{3{lin[15]}}, lin} + $signed({9'd0, sq_prod[19:10]});
  end

  always_ff @(posedge clk) begin
    s5_scale <= scale_s[16:0];
    s5_total <= s4_total;
    s5_drive <= s4_drive;
    s5_note  <= s4_note;
  end

  // stage 6: frequency, rounded; scale stays above 0.86 so it never drops below 1
  always_comb begin
    f_prod = 31'(base_hz(s5_note)) * 31'(s5_scale) + Q16_HALF;
  end

  always_ff @(posedge clk) begin
    tone_freq_hz  <= f_prod[28:16];
    drive_volume  <= s5_drive;
    applied_cents <= s5_total;
  end

endmodule

// ===== rtl/pitch_bend_vibrato_tone_freq_core.sv =====
// Top level of the pitch bend / vibrato tone frequency core.
//
//  channel   direction  transfer when         fields
//  command   in         start && !busy        note_sel volume_pct modulate stick_x
//                                              stick_y lfo_elapsed_ms
//  result    out        done (one cycle)      tone_freq_hz drive_volume applied_cents
//
// One command per cycle is accepted, and each yields one result on done.
// Latency is set by the six-stage back pipeline plus the queue slot between front and back.
// The back pipeline never stalls, so the queue drains every cycle and busy stays low.
// Synchronous reset on rst empties the queue and the pipeline valid bits.
module pitch_bend_vibrato_tone_freq_core import pbv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         note_sel,
  input  logic [6:0]         volume_pct,
  input  logic               modulate,
  input  logic signed [10:0] stick_x,
  input  logic signed [10:0] stick_y,
  input  logic [31:0]        lfo_elapsed_ms,
  output logic               done,
  output logic [12:0]        tone_freq_hz,
  output logic [11:0]        drive_volume,
  output logic signed [8:0]  applied_cents
);

  logic        push;
  front_item_t push_item;
  front_item_t head;
  logic        head_valid;

  pbv_front u_front (
    .start          (start),
    .busy           (busy),
    .note_sel       (note_sel),
    .volume_pct     (volume_pct),
    .modulate       (modulate),
    .stick_x        (stick_x),
    .stick_y        (stick_y),
    .lfo_elapsed_ms (lfo_elapsed_ms),
    .push           (push),
    .item           (push_item)
  );

  pbv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (head_valid),
    .head       (head),
    .head_valid (head_valid),
    .full       (busy)
  );

  pbv_back u_back (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (head_valid),
    .in_item       (head),
    .done          (done),
    .tone_freq_hz  (tone_freq_hz),
    .drive_volume  (drive_volume),
    .applied_cents (applied_cents)
  );

  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##7 done)
    else $error("result missing seven cycles after transfer");

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("queue backed up");

  a_cents_clamped: assert property (@(posedge clk) disable iff (rst)
    done |-> (applied_cents <= 9'sd250 && applied_cents >= -9'sd250))
    else $error("applied cents outside clamp");

  a_freq_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> (tone_freq_hz != 13'd0))
    else $error("zero frequency");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the pitch bend / vibrato tone frequency core.
class tone_scoreboard;
  typedef struct packed {
    logic [12:0]       freq;
    logic [11:0]       vol;
    logic signed [8:0] cents;
  } tone_result_t;

  tone_result_t awaited[$];
  int errors;
  int commands;
  int compared;
  int clamped;
  int unmodulated;
  logic [12:0] note_hz[8];

  function new();
    note_hz = '{13'd2093, 13'd2349, 13'd2637, 13'd2794,
                13'd3136, 13'd3520, 13'd3951, 13'd4186};
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  // Computes the expected tone for one accepted command and queues it.
  function void note_command(logic [2:0] note, logic [6:0] pct, logic modulate,
                             logic signed [10:0] sx, logic signed [10:0] sy,
                             logic [31:0] ms);
    int bend;
    int depth;
    int lfo;
    int ph;
    int total;
    int unsigned vol_sat;
    longint sq;
    longint scale;
    longint f;
    tone_result_t r;
    r.freq = note_hz[note];
    total = 0;
    if (modulate) begin
      bend = (int'(sx) * 200) / 1000;
      depth = (sy > 0) ? (int'(sy) * 50) / 1000 : 0;
      lfo = 0;
      if (depth > 0) begin
        ph = int'(ms % 32'd200);
        if (ph < 50) lfo = (ph * depth) / 50;
        else if (ph < 150) lfo = ((100 - ph) * depth) / 50;
        else lfo = ((ph - 200) * depth) / 50;
      end
      total = bend + lfo;
      if (total > 250 || total < -250) clamped++;
      if (total > 250) total = 250;
      else if (total < -250) total = -250;
      if (total != 0) begin
        sq = (longint'(11) * total * total) / 1024;
        scale = 65536 + longint'(38) * total + sq;
        f = (longint'(note_hz[note]) * scale + 32768) / 65536;
        r.freq = (f < 1) ? 13'd1 : f[12:0];
      end
    end else begin
      unmodulated++;
    end
    vol_sat = (pct > 7'd100) ? 100 : pct;
    r.vol = 12'((vol_sat * 4095) / 100);
    r.cents = total[8:0];
    awaited.push_back(r);
    commands++;
  endfunction

  function void check_result(logic [12:0] freq, logic [11:0] vol,
                             logic signed [8:0] cents);
    tone_result_t e;
    if (awaited.size() == 0) begin
      $display("%0t: unexpected result freq=%0d vol=%0d cents=%0d",
               $realtime, freq, vol, cents);
      errors++;
      return;
    end
    e = awaited.pop_front();
    compared++;
    if (freq !== e.freq) begin
      $display("%0t: tone_freq_hz expected %0d actual %0d", $realtime, e.freq, freq);
      errors++;
    end
    if (vol !== e.vol) begin
      $display("%0t: drive_volume expected %0d actual %0d", $realtime, e.vol, vol);
      errors++;
    end
    if (cents !== e.cents) begin
      $display("%0t: applied_cents expected %0d actual %0d", $realtime, e.cents, cents);
      errors++;
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int LATENCY = 7;
  localparam int PHASE_ITEMS = 376;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         note_sel = '0;
  logic [6:0]         volume_pct = '0;
  logic               modulate = 1'b0;
  logic signed [10:0] stick_x = '0;
  logic signed [10:0] stick_y = '0;
  logic [31:0]        lfo_elapsed_ms = '0;
  logic               done;
  logic [12:0]        tone_freq_hz;
  logic [11:0]        drive_volume;
  logic signed [8:0]  applied_cents;

  tone_scoreboard sb = new();
  int stall_cycles = 0;

  pitch_bend_vibrato_tone_freq_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .note_sel       (note_sel),
    .volume_pct     (volume_pct),
    .modulate       (modulate),
    .stick_x        (stick_x),
    .stick_y        (stick_y),
    .lfo_elapsed_ms (lfo_elapsed_ms),
    .done           (done),
    .tone_freq_hz   (tone_freq_hz),
    .drive_volume   (drive_volume),
    .applied_cents  (applied_cents)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        sb.note_command(note_sel, volume_pct, modulate, stick_x, stick_y,
                        lfo_elapsed_ms);
      end
      if (done) begin
        sb.check_result(tone_freq_hz, drive_volume, applied_cents);
      end
      if ((start && !busy) || done) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // Holds start high until the command transfers.
  task automatic send_command(logic [2:0] note, logic [6:0] pct, logic mod,
                              logic signed [10:0] sx, logic signed [10:0] sy,
                              logic [31:0] ms);
    note_sel <= note;
    volume_pct <= pct;
    modulate <= mod;
    stick_x <= sx;
    stick_y <= sy;
    lfo_elapsed_ms <= ms;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic pace(int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_random();
    logic signed [10:0] sx;
    logic signed [10:0] sy;
    logic [31:0] ms;
    logic mod;
    sx = ($urandom_range(9) < 8) ? 11'($urandom_range(2000) - 1000) : 11'($urandom);
    sy = ($urandom_range(9) < 8) ? 11'($urandom_range(2000) - 1000) : 11'($urandom);
    ms = $urandom_range(1) ? $urandom : $urandom_range(999);
    mod = ($urandom_range(3) != 0);
    send_command(3'($urandom), 7'($urandom_range(127)), mod, sx, sy, ms);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  task automatic random_phase(int idle_pct);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      pace(idle_pct);
      send_random();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: notes, volume saturation, lfo phase corners, clamp, stick extremes
    for (int n = 0; n < 8; n++) send_command(3'(n), 7'd50, 1'b0, 11'sd1000, 11'sd1000, 32'd25);
    send_command(3'd0, 7'd0,   1'b1, 11'sd0,     11'sd0,     32'd0);
    send_command(3'd7, 7'd100, 1'b1, 11'sd1000,  -11'sd1000, 32'd0);
    send_command(3'd7, 7'd101, 1'b1, -11'sd1000, 11'sd0,     32'd0);
    send_command(3'd3, 7'd127, 1'b1, 11'sd1023,  11'sd1023,  32'd50);
    send_command(3'd0, 7'd1,   1'b1, -11'sd1024, 11'sd1023,  32'd150);
    send_command(3'd5, 7'd99,  1'b1, 11'sd0,     11'sd1000,  32'd49);
    send_command(3'd5, 7'd64,  1'b1, 11'sd0,     11'sd1000,  32'd149);
    send_command(3'd5, 7'd33,  1'b1, 11'sd0,     11'sd1000,  32'd199);
    send_command(3'd6, 7'd77,  1'b1, 11'sd5,     11'sd19,    32'd50);
    send_command(3'd2, 7'd10,  1'b1, -11'sd3,    -11'sd1024, 32'hFFFF_FFFF);
    send_command(3'd1, 7'd42,  1'b1, 11'sd500,   11'sd600,   32'd100);
    send_command(3'd4, 7'd85,  1'b0, -11'sd1024, 11'sd1023,  32'hFFFF_FFFF);
    send_command(3'd7, 7'd127, 1'b1, -11'sd1024, -11'sd1024, 32'd123);
    drain_results();

    random_phase(11);
    drain_results();
    random_phase(53);
    drain_results();
    random_phase(0);
    drain_results();

    $display("ran %0d commands, %0d results compared", sb.commands, sb.compared);
    $display("%0d with offset clamped, %0d unmodulated", sb.clamped, sb.unmodulated);
    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
